// File: rtl/slta_pkg.sv
package slta_pkg;

  localparam int INDEX_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOPOLOGY_MODE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESTART_VALUE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AUTO_INDEX    = 2'd2;

  localparam logic TOPOLOGY_STRIP = 1'b0;
  localparam logic TOPOLOGY_LIST  = 1'b1;

  typedef struct packed {
    logic   topology_mode;
    index_t restart_value;
    logic   auto_index;
  } cfg_t;

  typedef struct packed {
    field_t first_corner;
    field_t second_corner;
    field_t third_corner;
    logic   triangle_valid;
    logic   stream_end;
  } result_t;

  function automatic field_t widen(input index_t v);
    field_t r;
    r = '0;
    r[INDEX_WIDTH-1:0] = v;
    return r;
  endfunction

endpackage

// File: rtl/slta_cfg_regs.sv
module slta_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [slta_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  slta_pkg::field_t                    wr_data,
  output slta_pkg::cfg_t                      cfg
);
  import slta_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.topology_mode <= TOPOLOGY_STRIP;
      cfg.restart_value <= '1;
      cfg.auto_index    <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TOPOLOGY_MODE: cfg.topology_mode <= wr_data[0];
        CFG_RESTART_VALUE: cfg.restart_value <= wr_data[INDEX_WIDTH-1:0];
        CFG_AUTO_INDEX:    cfg.auto_index    <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/slta_core.sv
module slta_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  slta_pkg::field_t    vertex_index,
  input  logic                stream_last,
  input  slta_pkg::cfg_t      cfg,
  output logic                emit,
  output slta_pkg::result_t   res
);
  import slta_pkg::*;

  index_t     older, older_next;
  index_t     newer, newer_next;
  logic [1:0] fill, fill_next;
  logic       parity, parity_next;
  index_t     seq, seq_next;

  index_t idx;
  logic   is_restart;
  logic   tri_hit;
  index_t c0, c1, c2;

  always_comb begin
    older_next  = older;
    newer_next  = newer;
    fill_next   = fill;
    parity_next = parity;
    seq_next    = seq;
    tri_hit     = 1'b0;
    c0          = '0;
    c1          = '0;
    c2          = '0;

    if (cfg.auto_index) begin
      idx      = seq;
      seq_next = seq + 1'b1;
    end else begin
      idx = vertex_index[INDEX_WIDTH-1:0];
    end
    is_restart = !cfg.auto_index && (idx == cfg.restart_value);

    if (cfg.topology_mode == TOPOLOGY_LIST) begin
      if (fill >= 2'd2) begin
        c0        = older;
        c1        = newer;
        c2        = idx;
        tri_hit   = 1'b1;
        fill_next = 2'd0;
      end else begin
        older_next = newer;
        newer_next = idx;
        fill_next  = fill + 2'd1;
      end
    end else if (is_restart) begin
      fill_next   = 2'd0;
      parity_next = 1'b0;
    end else if (fill >= 2'd2) begin
      c0          = parity ? newer : older;
      c1          = parity ? older : newer;
      c2          = idx;
      tri_hit     = 1'b1;
      parity_next = !parity;
      older_next  = newer;
      newer_next  = idx;
    end else begin
      older_next = newer;
      newer_next = idx;
      fill_next  = fill + 2'd1;
    end

    if (stream_last) begin
      older_next  = '0;
      newer_next  = '0;
      fill_next   = 2'd0;
      parity_next = 1'b0;
      seq_next    = '0;
    end

    emit               = tri_hit || stream_last;
    res.first_corner   = widen(c0);
    res.second_corner  = widen(c1);
    res.third_corner   = widen(c2);
    res.triangle_valid = tri_hit;
    res.stream_end     = stream_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older  <= '0;
      newer  <= '0;
      fill   <= 2'd0;
      parity <= 1'b0;
      seq    <= '0;
    end else if (accept) begin
      older  <= older_next;
      newer  <= newer_next;
      fill   <= fill_next;
      parity <= parity_next;
      seq    <= seq_next;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && stream_last |=> fill == 2'd0 && !parity && seq == '0)
    else $error("stream state not cleared after last beat");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cfg.topology_mode == TOPOLOGY_STRIP && is_restart
    |=> fill == 2'd0 && !parity)
    else $error("strip restart did not clear window");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("window fill out of range");

  a_list_parity: assert property (@(posedge clk) disable iff (rst)
    accept && cfg.topology_mode == TOPOLOGY_LIST && !stream_last |=> parity == $past(parity))
    else $error("list mode changed strip parity");
`endif

endmodule

// File: rtl/slta_out_reg.sv
module slta_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              emit,
  input  slta_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_stall,
  output slta_pkg::result_t out_res,
  output logic              accept
);
  import slta_pkg::*;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_res <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("held result lost or changed");

  a_load_source: assert property (@(posedge clk) disable iff (rst)
    !$past(accept && emit) && out_valid |-> $past(out_valid))
    else $error("result appeared without an emitting beat");
`endif

endmodule

// File: rtl/strip_to_list_assembler.sv
// strip_to_list_assembler: vertex index stream to triangle primitives.
// A result is registered and presented in the cycle after the beat that causes it.
// Throughput: one input beat per cycle; the single result register refills
// in the cycle it drains, so input stalls only while a held result is stalled.
// Reset (rst, synchronous): clears window, parity, counter and output valid;
// configuration returns to strip mode, restart value all ones, auto index off.
module strip_to_list_assembler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  slta_pkg::field_t                     vertex_index,
  input  logic                                 stream_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output slta_pkg::field_t                     first_corner,
  output slta_pkg::field_t                     second_corner,
  output slta_pkg::field_t                     third_corner,
  output logic                                 triangle_valid,
  output logic                                 stream_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [slta_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  slta_pkg::field_t                     cfg_data
);
  import slta_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    emit;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  slta_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  slta_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .vertex_index (vertex_index),
    .stream_last  (stream_last),
    .cfg          (cfg),
    .emit         (emit),
    .res          (res)
  );

  slta_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .emit      (emit),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .accept    (accept)
  );

  assign first_corner   = out_res.first_corner;
  assign second_corner  = out_res.second_corner;
  assign third_corner   = out_res.third_corner;
  assign triangle_valid = out_res.triangle_valid;
  assign stream_end     = out_res.stream_end;

endmodule

// File: test/strip_to_list_assembler_checker.sv
`timescale 1ns / 1ps
module strip_to_list_assembler_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  slta_pkg::field_t                     vertex_index,
  input  logic                                 stream_last,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  slta_pkg::field_t                     first_corner,
  input  slta_pkg::field_t                     second_corner,
  input  slta_pkg::field_t                     third_corner,
  input  logic                                 triangle_valid,
  input  logic                                 stream_end,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [slta_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  slta_pkg::field_t                     cfg_data,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   triangles_seen,
  output int                                   ends_seen
);
  import slta_pkg::*;

  logic       topology;
  index_t     restart_index;
  logic       auto_on;

  index_t     older_vtx;
  index_t     newer_vtx;
  logic [1:0] window_count;
  logic       odd_tri;
  index_t     auto_count;

  result_t    expected_triangles[$];

  assign outstanding = expected_triangles.size();

  task automatic clear_window();
    older_vtx = '0;
    newer_vtx = '0;
    window_count = '0;
    odd_tri = 1'b0;
    auto_count = '0;
  endtask

  task automatic apply_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input field_t data);
    case (idx)
      CFG_TOPOLOGY_MODE: topology = data[0];
      CFG_RESTART_VALUE: restart_index = index_t'(data);
      CFG_AUTO_INDEX:    auto_on = data[0];
      default: ;
    endcase
  endtask

  task automatic assemble_index(input field_t v, input logic last);
    index_t  idx;
    logic    formed;
    result_t exp_res;
    formed = 1'b0;
    exp_res = '0;
    if (auto_on) begin
      idx = auto_count;
      auto_count = auto_count + 1'b1;
    end else begin
      idx = index_t'(v);
    end
    if (topology == TOPOLOGY_LIST) begin
      if (window_count >= 2) begin
        exp_res.first_corner = field_t'(older_vtx);
        exp_res.second_corner = field_t'(newer_vtx);
        exp_res.third_corner = field_t'(idx);
        formed = 1'b1;
        window_count = '0;
      end else begin
        older_vtx = newer_vtx;
        newer_vtx = idx;
        window_count = window_count + 1'b1;
      end
    end else if (!auto_on && idx == restart_index) begin
      window_count = '0;
      odd_tri = 1'b0;
    end else if (window_count >= 2) begin
      exp_res.first_corner = field_t'(odd_tri ? newer_vtx : older_vtx);
      exp_res.second_corner = field_t'(odd_tri ? older_vtx : newer_vtx);
      exp_res.third_corner = field_t'(idx);
      formed = 1'b1;
      odd_tri = ~odd_tri;
      older_vtx = newer_vtx;
      newer_vtx = idx;
    end else begin
      older_vtx = newer_vtx;
      newer_vtx = idx;
      window_count = window_count + 1'b1;
    end
    if (formed || last) begin
      exp_res.triangle_valid = formed;
      exp_res.stream_end = last;
      expected_triangles = {expected_triangles, exp_res};
    end
    if (last) clear_window();
  endtask

  task automatic check_beat();
    result_t exp_tri;
    if (expected_triangles.size() == 0) begin
      $error("output beat with nothing expected");
      mismatches++;
    end else begin
      exp_tri = expected_triangles.pop_front();
      if (first_corner !== exp_tri.first_corner) begin
        $error("first_corner expected %h actual %h", exp_tri.first_corner, first_corner);
        mismatches++;
      end
      if (second_corner !== exp_tri.second_corner) begin
        $error("second_corner expected %h actual %h", exp_tri.second_corner, second_corner);
        mismatches++;
      end
      if (third_corner !== exp_tri.third_corner) begin
        $error("third_corner expected %h actual %h", exp_tri.third_corner, third_corner);
        mismatches++;
      end
      if (triangle_valid !== exp_tri.triangle_valid) begin
        $error("triangle_valid expected %b actual %b", exp_tri.triangle_valid,
               triangle_valid);
        mismatches++;
      end
      if (stream_end !== exp_tri.stream_end) begin
        $error("stream_end expected %b actual %b", exp_tri.stream_end, stream_end);
        mismatches++;
      end
    end
    if (triangle_valid === 1'b1) triangles_seen++;
    if (stream_end === 1'b1) ends_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      topology = TOPOLOGY_STRIP;
      restart_index = '1;
      auto_on = 1'b0;
      clear_window();
      expected_triangles.delete();
      mismatches = 0;
      triangles_seen = 0;
      ends_seen = 0;
    end else begin
      // a result at this edge comes from an earlier beat
      if (out_valid && !out_stall) check_beat();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) assemble_index(vertex_index, stream_last);
    end
  end

endmodule

// File: test/strip_to_list_assembler_test.sv
`timescale 1ns / 1ps
module strip_to_list_assembler_test;
  import slta_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 4000;
  localparam int BEAT_TARGET = 1850;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  field_t                     vertex_index = '0;
  logic                       stream_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  field_t                     first_corner;
  field_t                     second_corner;
  field_t                     third_corner;
  logic                       triangle_valid;
  logic                       stream_end;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  field_t                     cfg_data = '0;

  int     mismatches;
  int     outstanding;
  int     triangles_seen;
  int     ends_seen;
  int     beats_sent = 0;
  int     writes_done = 0;
  int     round_num = 0;
  logic   tx_idle_on = 1'b1;
  logic   rx_idle_on = 1'b1;
  logic   hold_req = 1'b0;
  index_t cur_restart = '1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  strip_to_list_assembler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_index(vertex_index), .stream_last(stream_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_corner(first_corner), .second_corner(second_corner),
    .third_corner(third_corner), .triangle_valid(triangle_valid),
    .stream_end(stream_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  strip_to_list_assembler_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vertex_index(vertex_index), .stream_last(stream_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_corner(first_corner), .second_corner(second_corner),
    .third_corner(third_corner), .triangle_valid(triangle_valid),
    .stream_end(stream_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .triangles_seen(triangles_seen), .ends_seen(ends_seen)
  );

  // receiver; a hold request keeps the output stalled for a long stretch
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = rx_idle_on && ($urandom_range(99) < 36);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("strip_to_list_assembler test failed");
    $finish;
  end

  task automatic send_beat(input field_t v, input logic last);
    while (tx_idle_on && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    vertex_index = v;
    stream_last = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input field_t data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    writes_done++;
    if (idx == CFG_RESTART_VALUE) cur_restart = index_t'(data);
  endtask

  // single-bit registers get random upper bits, which must be dropped
  task automatic configure(input logic topo, input field_t restart, input logic auto_flag);
    field_t d;
    settle();
    d = $urandom();
    d[0] = topo;
    write_reg(CFG_TOPOLOGY_MODE, d);
    write_reg(CFG_RESTART_VALUE, restart);
    d = $urandom();
    d[0] = auto_flag;
    write_reg(CFG_AUTO_INDEX, d);
  endtask

  function automatic field_t pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 10) return field_t'(cur_restart);
    if (r < 25) return $urandom();
    if (r < 35) return 32'hFFFF_FFC0 | $urandom_range(63);
    return $urandom_range(63);
  endfunction

  task automatic send_stream(input int len, input logic terminate);
    for (int i = 0; i < len; i++)
      send_beat(pick_index(), terminate && (i == len - 1));
  endtask

  initial begin
    field_t restart;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // strip defaults: even/odd order, restart, lone last, restart as last
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFE, 1'b0);
    send_beat(32'h0000_0001, 1'b0);
    send_beat(32'h0000_0002, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h0000_0005, 1'b0);
    send_beat(32'h0000_0006, 1'b0);
    send_beat(32'h0000_0007, 1'b0);
    send_beat(32'h0000_0008, 1'b1);
    send_beat(32'h0000_0009, 1'b1);
    send_beat(32'hFFFF_FFFF, 1'b1);

    // list mode: restart value is an ordinary index; partial group at end
    configure(TOPOLOGY_LIST, 32'h0, 1'b0);
    write_reg(CFG_SPARE, 32'hA5A5_5A5A);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0000_000A, 1'b0);
    send_beat(32'h0000_000B, 1'b0);
    send_beat(32'h0000_000C, 1'b0);
    send_beat(32'h0000_000D, 1'b1);

    // auto index in strip mode, supplied values ignored
    configure(TOPOLOGY_STRIP, 32'h0, 1'b1);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h1234_5678, 1'b0);
    send_beat(32'h0000_0000, 1'b1);

    // switch to list with a full window
    configure(TOPOLOGY_STRIP, 32'h0, 1'b0);
    send_beat(32'h0000_0014, 1'b0);
    send_beat(32'h0000_0015, 1'b0);
    settle();
    write_reg(CFG_TOPOLOGY_MODE, field_t'(TOPOLOGY_LIST));
    send_beat(32'h0000_0016, 1'b1);

    while (beats_sent < BEAT_TARGET) begin
      tx_idle_on = (round_num % 6 != 3);
      rx_idle_on = (round_num % 6 != 3);
      case ($urandom_range(3))
        0: restart = 32'h0;
        1: restart = 32'hFFFF_FFFF;
        2: restart = $urandom();
        default: restart = $urandom_range(63);
      endcase
      configure(($urandom_range(1) == 1) ? TOPOLOGY_LIST : TOPOLOGY_STRIP, restart,
                $urandom_range(3) == 0);
      if ($urandom_range(3) == 0) write_reg(CFG_SPARE, $urandom());
      if (round_num % 7 == 2) hold_req = 1'b1;
      repeat ($urandom_range(3, 10))
        send_stream($urandom_range(1, 30), $urandom_range(99) < 90);
      round_num++;
    end

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("%0d index beats in %0d rounds, %0d register writes", beats_sent, round_num,
             writes_done);
    $display("%0d triangles and %0d stream ends checked", triangles_seen, ends_seen);
    if (mismatches == 0 && outstanding == 0)
      $display("strip_to_list_assembler test passed");
    else
      $display("strip_to_list_assembler test failed");
    $finish;
  end

endmodule
